### hw/rtl/utf8e_pkg.sv
package utf8e_pkg;

    localparam int unsigned CP_W   = 31;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 3;

    localparam logic [CP_W-1:0] LIMIT_STRICT = 31'h80;
    localparam logic [CP_W-1:0] LIMIT_LOOSE  = 31'hC0;
    localparam logic [1:0]      CONT_TAG     = 2'b10;

    // Sequence length codes
    localparam logic [LEN_W-1:0] LEN_1 = 3'd1;
    localparam logic [LEN_W-1:0] LEN_2 = 3'd2;
    localparam logic [LEN_W-1:0] LEN_3 = 3'd3;
    localparam logic [LEN_W-1:0] LEN_4 = 3'd4;
    localparam logic [LEN_W-1:0] LEN_5 = 3'd5;
    localparam logic [LEN_W-1:0] LEN_6 = 3'd6;

    typedef struct packed {
        logic [CP_W-1:0]  cp;
        logic [LEN_W-1:0] len;
    } t_item;

    // Byte idx of an len-byte sequence for code point cp.
    function automatic logic [BYTE_W-1:0] f_byte(
        input logic [CP_W-1:0]  cp,
        input logic [LEN_W-1:0] len,
        input logic [LEN_W-1:0] idx
    );
        logic [LEN_W-1:0]  j;
        logic [5:0]        ch;
        logic [BYTE_W-1:0] res;
        j   = len - idx - LEN_1;
        ch  = cp[5:0];
        res = cp[7:0];
        if (len == LEN_1) begin
            res = cp[7:0];
        end else if (idx == '0) begin
            unique case (len)
                LEN_2:   res = {3'b110, cp[10:6]};
                LEN_3:   res = {4'b1110, cp[15:12]};
                LEN_4:   res = {5'b11110, cp[20:18]};
                LEN_5:   res = {6'b111110, cp[25:24]};
                LEN_6:   res = {7'b1111110, cp[30]};
                default: res = cp[7:0];
            endcase
        end else begin
            case (j)
                3'd0:    ch = cp[5:0];
                3'd1:    ch = cp[11:6];
                3'd2:    ch = cp[17:12];
                3'd3:    ch = cp[23:18];
                3'd4:    ch = cp[29:24];
                default: ch = cp[5:0];
            endcase
            res = {CONT_TAG, ch};
        end
        return res;
    endfunction

endpackage

### hw/rtl/utf8e_front.sv
module utf8e_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_strict_mode_we,
    input  logic                          i_strict_mode,
    input  logic [utf8e_pkg::CP_W-1:0]    i_code_point,
    output utf8e_pkg::t_item              o_item
);

    logic                         r_strict;
    logic [utf8e_pkg::CP_W-1:0]   limit;
    logic [utf8e_pkg::LEN_W-1:0]  len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strict <= 1'b1;
        end else if (i_strict_mode_we) begin
            r_strict <= i_strict_mode;
        end
    end

    // Shortest form: n >= 2 bytes hold values below 2^(5n+1)
    always_comb begin
        limit = r_strict ? utf8e_pkg::LIMIT_STRICT : utf8e_pkg::LIMIT_LOOSE;
        if (i_code_point < limit) begin
            len = utf8e_pkg::LEN_1;
        end else if (i_code_point[30:11] == '0) begin
            len = utf8e_pkg::LEN_2;
        end else if (i_code_point[30:16] == '0) begin
            len = utf8e_pkg::LEN_3;
        end else if (i_code_point[30:21] == '0) begin
            len = utf8e_pkg::LEN_4;
        end else if (i_code_point[30:26] == '0) begin
            len = utf8e_pkg::LEN_5;
        end else begin
            len = utf8e_pkg::LEN_6;
        end
    end

    assign o_item.cp  = i_code_point;
    assign o_item.len = len;

endmodule

### hw/rtl/utf8e_queue.sv
module utf8e_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  utf8e_pkg::t_item  i_item,
    input  logic              i_pop,
    output logic              o_valid,
    output logic              o_full,
    output utf8e_pkg::t_item  o_item
);

    utf8e_pkg::t_item r_mem [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_item  = r_mem[r_rptr];

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count overflow");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop)
        else $error("pop from empty queue");

endmodule

### hw/rtl/utf8e_back.sv
module utf8e_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  utf8e_pkg::t_item               i_q_item,
    output logic                           o_q_pop,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [utf8e_pkg::BYTE_W-1:0]   o_out_byte,
    output logic [utf8e_pkg::LEN_W-1:0]    o_seq_length,
    output logic                           o_last_byte
);

    logic                          r_busy;
    logic [utf8e_pkg::CP_W-1:0]    r_cp;
    logic [utf8e_pkg::LEN_W-1:0]   r_len;
    logic [utf8e_pkg::LEN_W-1:0]   r_idx;
    logic                          r_ovalid;
    logic [utf8e_pkg::BYTE_W-1:0]  r_byte;
    logic [utf8e_pkg::LEN_W-1:0]   r_olen;
    logic                          r_olast;

    logic                          src_valid;
    logic [utf8e_pkg::CP_W-1:0]    src_cp;
    logic [utf8e_pkg::LEN_W-1:0]   src_len;
    logic [utf8e_pkg::LEN_W-1:0]   src_idx;
    logic                          src_last;
    logic                          load;
    logic                          n_busy;
    logic                          n_ovalid;

    // Work from the held item if mid-sequence, else straight from the queue head
    always_comb begin
        src_valid = r_busy || i_q_valid;
        src_cp    = r_busy ? r_cp  : i_q_item.cp;
        src_len   = r_busy ? r_len : i_q_item.len;
        src_idx   = r_busy ? r_idx : '0;
        src_last  = (src_idx == (src_len - utf8e_pkg::LEN_1));
        load      = src_valid && (!r_ovalid || !i_stall);
        n_busy    = load ? !src_last : r_busy;
        n_ovalid  = load ? 1'b1 : (r_ovalid && i_stall);
    end

    assign o_q_pop = load && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cp    <= src_cp;
            r_len   <= src_len;
            r_idx   <= src_idx + utf8e_pkg::LEN_1;
            r_byte  <= utf8e_pkg::f_byte(src_cp, src_len, src_idx);
            r_olen  <= src_len;
            r_olast <= src_last;
        end
    end

    assign o_valid      = r_ovalid;
    assign o_out_byte   = r_byte;
    assign o_seq_length = r_olen;
    assign o_last_byte  = r_olast;

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_seq_length >= utf8e_pkg::LEN_1 && o_seq_length <= utf8e_pkg::LEN_6))
        else $error("sequence length out of range");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_seq_length == utf8e_pkg::LEN_1) |-> o_last_byte)
        else $error("single-byte item not marked last");

    a_idx_in_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx < r_len))
        else $error("byte index past sequence end");

endmodule

### hw/rtl/utf8_code_point_encoder_top.sv
// Path: an accepted item is written into the two-entry queue, then the byte
//   serializer loads its bytes in turn into the registered output.
// Throughput: one output byte per cycle while i_stall is low, so one item
//   per cycle for single-byte characters, paced by the byte serializer.
// Reset (i_rst_n low, synchronous): queue and output empty, strict mode set.
module utf8_code_point_encoder_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_strict_mode_we,
    input  logic                          i_strict_mode,
    // input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [utf8e_pkg::CP_W-1:0]    i_code_point,
    // output channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [utf8e_pkg::BYTE_W-1:0]  o_out_byte,
    output logic [utf8e_pkg::LEN_W-1:0]   o_seq_length,
    output logic                          o_last_byte
);

    utf8e_pkg::t_item f_item;   // classified item from front
    utf8e_pkg::t_item q_item;   // queue head
    logic             q_valid;
    logic             q_full;
    logic             q_pop;
    logic             push;

    // Front: holds strict_mode and picks the sequence length per item
    utf8e_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_strict_mode_we (i_strict_mode_we),
        .i_strict_mode    (i_strict_mode),
        .i_code_point     (i_code_point),
        .o_item           (f_item)
    );

    // Input side stalls only when the two-entry queue is full
    assign o_stall = q_full;
    assign push    = i_valid && !q_full;

    utf8e_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_item  (q_item)
    );

    // Back: serializes lead and continuation bytes into a registered output
    utf8e_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_item     (q_item),
        .o_q_pop      (q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_seq_length (o_seq_length),
        .o_last_byte  (o_last_byte)
    );

endmodule

### dv/utf8_code_point_encoder_top_test.sv
`timescale 1ns / 100ps

module utf8_code_point_encoder_top_test;

    // Generous bound: ~110 code points, up to 6 bytes each, heavy stalling.
    localparam int unsigned CYCLE_LIMIT = 200000;
    // Idle cycles after the last expected byte: covers the byte serializer.
    localparam int unsigned TAIL_CYCLES = 20;
    localparam int unsigned RAND_ITEMS_PER_PHASE = 22;
    localparam int unsigned MAX_PRINTED = 50;

    // strict_mode register values
    localparam logic MODE_LOOSE  = 1'b0;
    localparam logic MODE_STRICT = 1'b1;

    typedef enum int {
        PACE_NONE,
        PACE_SENDER,
        PACE_RECEIVER,
        PACE_BOTH
    } t_pace;

    // One expected output byte, tagged with the code point that caused it
    typedef struct packed {
        logic [utf8e_pkg::CP_W-1:0]   code_point;
        logic [utf8e_pkg::BYTE_W-1:0] out_byte;
        logic [utf8e_pkg::LEN_W-1:0]  seq_length;
        logic                         last_byte;
    } t_enc_byte;

    logic                          i_clk            = 1'b0;
    logic                          i_rst_n          = 1'b0;
    logic                          i_strict_mode_we = 1'b0;
    logic                          i_strict_mode    = MODE_STRICT;
    logic                          i_valid          = 1'b0;
    logic [utf8e_pkg::CP_W-1:0]    i_code_point     = '0;
    logic                          i_stall          = 1'b0;
    logic                          o_stall;
    logic                          o_valid;
    logic [utf8e_pkg::BYTE_W-1:0]  o_out_byte;
    logic [utf8e_pkg::LEN_W-1:0]   o_seq_length;
    logic                          o_last_byte;

    // Scoreboard state
    t_enc_byte   pending_bytes[$];
    logic        strict_shadow = MODE_STRICT;     // tracks the register
    int unsigned sender_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned error_count = 0;
    int unsigned items_sent = 0;
    int unsigned bytes_checked = 0;
    int unsigned cycle_count = 0;
    int unsigned lengths_seen [1:6] = '{0, 0, 0, 0, 0, 0};

    utf8_code_point_encoder_top uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_strict_mode_we (i_strict_mode_we),
        .i_strict_mode    (i_strict_mode),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_code_point     (i_code_point),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_out_byte       (o_out_byte),
        .o_seq_length     (o_seq_length),
        .o_last_byte      (o_last_byte)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Watchdog: a hang or a missing byte ends here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d bytes still expected",
                     cycle_count, pending_bytes.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver backpressure, redrawn every cycle
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Expected UTF-8 bytes of one code point under the current mode.
    // Length is the shortest n >= 2 with cp < 2^(5n+1); lead byte has n ones.
    function automatic void predict_utf8_bytes(input logic [utf8e_pkg::CP_W-1:0] cp);
        logic [31:0] wide;
        logic [31:0] lead;
        logic [31:0] limit;
        int unsigned n;
        int unsigned sh;
        t_enc_byte   b;
        wide  = {1'b0, cp};
        limit = {1'b0, (strict_shadow == MODE_STRICT) ? utf8e_pkg::LIMIT_STRICT
                                                      : utf8e_pkg::LIMIT_LOOSE};
        b.code_point = cp;
        if (wide < limit) begin
            // single raw byte; in loose mode this includes 0x80..0xBF
            b.out_byte   = wide[7:0];
            b.seq_length = utf8e_pkg::LEN_1;
            b.last_byte  = 1'b1;
            pending_bytes.push_back(b);
            lengths_seen[1]++;
            return;
        end
        n = 2;
        while (n < 6 && wide >= (32'd1 << (5 * n + 1)))
            n++;
        lead         = (32'hFF << (8 - n)) | (wide >> (6 * n - 6));
        b.out_byte   = lead[7:0];
        b.seq_length = n[utf8e_pkg::LEN_W-1:0];
        b.last_byte  = 1'b0;
        pending_bytes.push_back(b);
        for (int unsigned k = 1; k < n; k++) begin
            sh          = (n - k - 1) * 6;
            lead        = wide >> sh;
            b.out_byte  = {utf8e_pkg::CONT_TAG, lead[5:0]};
            b.last_byte = (k == n - 1);
            pending_bytes.push_back(b);
        end
        lengths_seen[n]++;
    endfunction

    // Byte checker: handshake values are stable at the falling edge
    always @(negedge i_clk) begin : check_bytes
        t_enc_byte want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %h (len %0d last %b)",
                                          o_out_byte, o_seq_length, o_last_byte));
            end else begin
                want = pending_bytes.pop_front();
                bytes_checked++;
                if (o_out_byte !== want.out_byte)
                    report_mismatch($sformatf("cp %h: out_byte %h, expected %h",
                                              want.code_point, o_out_byte, want.out_byte));
                if (o_seq_length !== want.seq_length)
                    report_mismatch($sformatf("cp %h: seq_length %0d, expected %0d",
                                              want.code_point, o_seq_length,
                                              want.seq_length));
                if (o_last_byte !== want.last_byte)
                    report_mismatch($sformatf("cp %h: last_byte %b, expected %b",
                                              want.code_point, o_last_byte, want.last_byte));
            end
        end
    end

    task automatic set_pacing(input t_pace pace);
        case (pace)
            PACE_NONE: begin
                sender_idle_pct = 0;
                stall_pct       = 0;
            end
            PACE_SENDER: begin
                sender_idle_pct = 81;
                stall_pct       = 0;
            end
            PACE_RECEIVER: begin
                sender_idle_pct = 0;
                stall_pct       = 81;
            end
            default: begin
                sender_idle_pct = 11;
                stall_pct       = 11;
            end
        endcase
    endtask

    // Drive one code point, wait for it to be taken, then maybe go idle.
    // Valid is left high when the next item follows back to back.
    task automatic send_code_point(input logic [utf8e_pkg::CP_W-1:0] cp);
        logic taken;
        i_valid      <= 1'b1;
        i_code_point <= cp;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end
        predict_utf8_bytes(cp);
        items_sent++;
        if ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
    endtask

    // Stop sending and let every expected byte come out
    task automatic settle_outputs();
        i_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_strict_mode(input logic mode);
        settle_outputs();
        i_strict_mode_we <= 1'b1;
        i_strict_mode    <= mode;
        @(posedge i_clk);
        i_strict_mode_we <= 1'b0;
        strict_shadow = mode;
    endtask

    // ASCII in two draws of nine, the rest spread over every length class, all-bits
    // values and the length thresholds +/- 1
    function automatic logic [utf8e_pkg::CP_W-1:0] rand_code_point();
        logic [31:0] v;
        logic [31:0] edge_val;
        case ($urandom_range(8, 0))
            0, 1: v = $urandom_range(32'h7F, 0);
            2:    v = $urandom_range(32'hFF, 32'h80);
            3:    v = $urandom_range(32'h7FF, 32'hC0);
            4:    v = $urandom_range(32'hFFFF, 32'h800);
            5:    v = $urandom_range(32'h1F_FFFF, 32'h1_0000);
            6:    v = $urandom_range(32'h3FF_FFFF, 32'h20_0000);
            7:    v = $urandom();
            default: begin
                case ($urandom_range(6, 0))
                    0:       edge_val = 32'h80;
                    1:       edge_val = 32'hC0;
                    2:       edge_val = 32'h800;
                    3:       edge_val = 32'h1_0000;
                    4:       edge_val = 32'h20_0000;
                    5:       edge_val = 32'h400_0000;
                    default: edge_val = 32'h8000_0000;
                endcase
                v = edge_val + $urandom_range(2, 0) - 1;
            end
        endcase
        return v[utf8e_pkg::CP_W-1:0];
    endfunction

    // Reset value of strict mode, every length threshold and the extremes
    task automatic test_length_boundaries();
        set_pacing(PACE_NONE);
        send_code_point(31'h0);
        send_code_point(31'h7F);
        send_code_point(31'h80);           // first two-byte value in strict mode
        send_code_point(31'h7FF);
        send_code_point(31'h800);          // shortest form must be three bytes
        send_code_point(31'hFFFF);
        send_code_point(31'h1_0000);       // shortest form must be four bytes
        send_code_point(31'h1F_FFFF);
        send_code_point(31'h20_0000);
        send_code_point(31'h3FF_FFFF);
        send_code_point(31'h400_0000);
        send_code_point(31'h7FFF_FFFF);    // largest value, six bytes
        send_code_point(31'h2AAA_AAAA);
        send_code_point(31'h5555_5555);
        settle_outputs();
    endtask

    // Loose mode passes 0x80..0xBF raw; then strict mode comes back
    task automatic test_loose_mode();
        write_strict_mode(MODE_LOOSE);
        send_code_point(31'h7F);
        send_code_point(31'h80);
        send_code_point(31'hBF);           // last raw byte
        send_code_point(31'hC0);           // first two-byte value in loose mode
        send_code_point(31'hFF);
        send_code_point(31'h7FF);
        write_strict_mode(MODE_STRICT);
        send_code_point(31'h80);
        send_code_point(31'hBF);
        settle_outputs();
    endtask

    // Random code points under each pacing phase, mode alternating
    task automatic test_random_traffic();
        t_pace pace;
        for (int p = PACE_NONE; p <= PACE_BOTH; p++) begin
            pace = t_pace'(p);
            write_strict_mode((p % 2 == 0) ? MODE_STRICT : MODE_LOOSE);
            set_pacing(pace);
            repeat (RAND_ITEMS_PER_PHASE)
                send_code_point(rand_code_point());
            settle_outputs();
        end
        set_pacing(PACE_NONE);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_length_boundaries();
        test_loose_mode();
        test_random_traffic();

        settle_outputs();
        $display("Encoded %0d code points into %0d checked bytes, strict and loose modes,",
                 items_sent, bytes_checked);
        $display("four pacing phases; sequences of 1..6 bytes: %0d %0d %0d %0d %0d %0d",
                 lengths_seen[1], lengths_seen[2], lengths_seen[3],
                 lengths_seen[4], lengths_seen[5], lengths_seen[6]);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/utf8e_pkg.sv
hw/rtl/utf8e_front.sv
hw/rtl/utf8e_queue.sv
hw/rtl/utf8e_back.sv
hw/rtl/utf8_code_point_encoder_top.sv
dv/utf8_code_point_encoder_top_test.sv
